>>> design/fmp_pkg.sv
// Shared definitions for the Firmata message parser: command codes, event kinds,
// enable bit positions and the operation record passed from the front to the back.
// No dependencies.
`default_nettype none

package fmp_pkg;

  localparam int FMP_FRAME_BYTES = 32;
  localparam int FMP_QUEUE_DEPTH = 4;

  localparam logic [7:0] CMD_ANALOG      = 8'hE0;
  localparam logic [7:0] CMD_DIGITAL     = 8'h90;
  localparam logic [7:0] CMD_REP_ANALOG  = 8'hC0;
  localparam logic [7:0] CMD_REP_DIGITAL = 8'hD0;
  localparam logic [7:0] CMD_PIN_MODE    = 8'hF4;
  localparam logic [7:0] CMD_SYSEX_START = 8'hF0;
  localparam logic [7:0] CMD_SYSEX_END   = 8'hF7;
  localparam logic [7:0] CMD_VERSION     = 8'hF9;
  localparam logic [7:0] CMD_RESET       = 8'hFF;
  localparam logic [7:0] SX_STRING       = 8'h71;
  localparam logic [7:0] SX_FIRMWARE     = 8'h79;
  localparam logic [7:0] STATUS_MASK     = 8'hF0;

  localparam logic [3:0] EV_ANALOG      = 4'd0;
  localparam logic [3:0] EV_DIGITAL     = 4'd1;
  localparam logic [3:0] EV_PIN_MODE    = 4'd2;
  localparam logic [3:0] EV_REP_ANALOG  = 4'd3;
  localparam logic [3:0] EV_REP_DIGITAL = 4'd4;
  localparam logic [3:0] EV_SYSEX       = 4'd5;
  localparam logic [3:0] EV_STRING      = 4'd6;
  localparam logic [3:0] EV_VERSION     = 4'd7;
  localparam logic [3:0] EV_FIRMWARE    = 4'd8;
  localparam logic [3:0] EV_RESET       = 4'd9;

  localparam int EN_ANALOG      = 0;
  localparam int EN_DIGITAL     = 1;
  localparam int EN_PIN_MODE    = 2;
  localparam int EN_REP_ANALOG  = 3;
  localparam int EN_REP_DIGITAL = 4;
  localparam int EN_STRING      = 5;
  localparam int EN_SYSEX       = 6;
  localparam int EN_RESET       = 7;

  localparam logic [7:0] ENABLE_RESET = 8'hFF;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_CLEAR,
    OP_FIXED,
    OP_FINISH,
    OP_SYSEX,
    OP_STRING
  } op_code_t;

  typedef enum logic [1:0] {
    VF_ZERO,
    VF_WIDE,
    VF_BYTE,
    VF_CHAR
  } val_form_t;

  typedef struct packed {
    op_code_t   code;
    logic [3:0] kind;
    val_form_t  vform;
    logic       ch_from_b;
    logic [3:0] ch;
    logic [7:0] data;
    logic [7:0] cmd;
    logic       ovf;
    logic       emit;
  } fmp_op_t;

endpackage

`default_nettype wire

>>> design/fmp_front.sv
// Front end of the Firmata message parser: accepts link bytes, tracks the parse state
// and the event enable register, and queues at most one operation per byte.
// Depends on fmp_pkg.
`default_nettype none

module fmp_front import fmp_pkg::*; #(
  parameter int FRAME_BYTES = FMP_FRAME_BYTES,
  localparam int CW = $clog2(FRAME_BYTES + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [7:0]    in_byte,
  input  wire logic          cfg_wr_en,
  input  wire logic [7:0]    cfg_wr_data,
  input  wire logic          q_full,
  output logic               push,
  output fmp_op_t            op,
  output logic [CW-1:0]      arg
);

  logic          in_sysex_r, in_sysex_nxt;
  logic [1:0]    awaited_r, awaited_nxt;
  logic [7:0]    pending_r, pending_nxt;
  logic [3:0]    chan_r, chan_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [7:0]    fcmd_r, fcmd_nxt;
  logic [7:0]    enable_r;
  logic          accept;
  logic [7:0]    cmd_v;

  assign accept = in_valid && !q_full;

  always_comb begin
    in_sysex_nxt = in_sysex_r;
    awaited_nxt  = awaited_r;
    pending_nxt  = pending_r;
    chan_nxt     = chan_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    fcmd_nxt     = fcmd_r;
    push         = 1'b0;
    op           = '0;
    op.code      = OP_WRITE;
    op.vform     = VF_ZERO;
    arg          = '0;
    cmd_v        = 8'h00;
    if (accept) begin
      if (in_sysex_r) begin
        if (in_byte == CMD_SYSEX_END) begin
          in_sysex_nxt = 1'b0;
          op.cmd = fcmd_r;
          op.ovf = ovf_r;
          arg    = count_r;
          if (count_r != '0) begin
            if (fcmd_r == SX_FIRMWARE) begin
              push    = 1'b1;
              op.code = OP_FIXED;
              op.kind = EV_FIRMWARE;
            end else if (fcmd_r == SX_STRING) begin
              if (enable_r[EN_STRING]) begin
                push    = 1'b1;
                op.kind = EV_STRING;
                if (count_r < CW'(3)) begin
                  op.code = OP_FIXED;
                end else begin
                  op.code  = OP_STRING;
                  op.vform = VF_CHAR;
                end
              end
            end else if (enable_r[EN_SYSEX]) begin
              push    = 1'b1;
              op.kind = EV_SYSEX;
              if (count_r == CW'(1)) begin
                op.code = OP_FIXED;
              end else begin
                op.code  = OP_SYSEX;
                op.vform = VF_BYTE;
              end
            end
          end
        end else if (count_r < CW'(FRAME_BYTES)) begin
          push      = 1'b1;
          op.code   = OP_WRITE;
          op.data   = in_byte;
          arg       = count_r;
          count_nxt = count_r + CW'(1);
          if (count_r == '0) begin
            fcmd_nxt = in_byte;
          end
        end else begin
          ovf_nxt = 1'b1;
        end
      end else if (awaited_r != 2'd0 && !in_byte[7]) begin
        awaited_nxt = awaited_r - 2'd1;
        push        = 1'b1;
        op.code     = OP_WRITE;
        op.data     = in_byte;
        op.ch       = chan_r;
        arg         = CW'(awaited_nxt[0]);
        if (awaited_nxt == 2'd0 && pending_r != 8'h00) begin
          pending_nxt = 8'h00;
          case (pending_r)
            CMD_ANALOG: begin
              if (enable_r[EN_ANALOG]) begin
                op.code  = OP_FINISH;
                op.kind  = EV_ANALOG;
                op.vform = VF_WIDE;
              end
            end
            CMD_DIGITAL: begin
              if (enable_r[EN_DIGITAL]) begin
                op.code  = OP_FINISH;
                op.kind  = EV_DIGITAL;
                op.vform = VF_WIDE;
              end
            end
            CMD_PIN_MODE: begin
              if (enable_r[EN_PIN_MODE]) begin
                op.code      = OP_FINISH;
                op.kind      = EV_PIN_MODE;
                op.vform     = VF_BYTE;
                op.ch_from_b = 1'b1;
              end
            end
            CMD_REP_ANALOG: begin
              if (enable_r[EN_REP_ANALOG]) begin
                op.code  = OP_FINISH;
                op.kind  = EV_REP_ANALOG;
                op.vform = VF_BYTE;
              end
            end
            CMD_REP_DIGITAL: begin
              if (enable_r[EN_REP_DIGITAL]) begin
                op.code  = OP_FINISH;
                op.kind  = EV_REP_DIGITAL;
                op.vform = VF_BYTE;
              end
            end
            default: begin
            end
          endcase
        end
      end else begin
        if (in_byte < CMD_SYSEX_START) begin
          cmd_v    = in_byte & STATUS_MASK;
          chan_nxt = in_byte[3:0];
        end else begin
          cmd_v = in_byte;
        end
        case (cmd_v)
          CMD_ANALOG, CMD_DIGITAL, CMD_PIN_MODE: begin
            awaited_nxt = 2'd2;
            pending_nxt = cmd_v;
          end
          CMD_REP_ANALOG, CMD_REP_DIGITAL: begin
            awaited_nxt = 2'd1;
            pending_nxt = cmd_v;
          end
          CMD_SYSEX_START: begin
            in_sysex_nxt = 1'b1;
            count_nxt    = '0;
            ovf_nxt      = 1'b0;
          end
          CMD_RESET: begin
            in_sysex_nxt = 1'b0;
            awaited_nxt  = 2'd0;
            pending_nxt  = 8'h00;
            chan_nxt     = 4'h0;
            count_nxt    = '0;
            ovf_nxt      = 1'b0;
            fcmd_nxt     = 8'h00;
            push         = 1'b1;
            op.code      = OP_CLEAR;
            op.kind      = EV_RESET;
            op.emit      = enable_r[EN_RESET];
          end
          CMD_VERSION: begin
            push    = 1'b1;
            op.code = OP_FIXED;
            op.kind = EV_VERSION;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sysex_r <= 1'b0;
      awaited_r  <= 2'd0;
      pending_r  <= 8'h00;
      chan_r     <= 4'h0;
      count_r    <= '0;
      ovf_r      <= 1'b0;
      fcmd_r     <= 8'h00;
      enable_r   <= ENABLE_RESET;
    end else begin
      in_sysex_r <= in_sysex_nxt;
      awaited_r  <= awaited_nxt;
      pending_r  <= pending_nxt;
      chan_r     <= chan_nxt;
      count_r    <= count_nxt;
      ovf_r      <= ovf_nxt;
      fcmd_r     <= fcmd_nxt;
      if (cfg_wr_en) begin
        enable_r <= cfg_wr_data;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/fmp_fifo.sv
// Short operation queue between the parser front and back.
// Generic width and depth; no package dependency.
`default_nettype none

module fmp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = $clog2(DEPTH),
  localparam int NW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  full,
  output logic                  empty
);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == NW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("Operation pushed into a full queue.");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("Operation popped from an empty queue.");
`endif

endmodule

`default_nettype wire

>>> design/fmp_back.sv
// Back end of the Firmata message parser: holds the frame store, executes queued
// operations and walks sysex frames, driving the registered result channel.
// Depends on fmp_pkg.
`default_nettype none

module fmp_back import fmp_pkg::*; #(
  parameter int FRAME_BYTES = FMP_FRAME_BYTES,
  localparam int CW = $clog2(FRAME_BYTES + 1),
  localparam int AW = $clog2(FRAME_BYTES)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire fmp_op_t       q_op,
  input  wire logic [CW-1:0] q_arg,
  output logic               q_pop,
  input  wire logic          out_stall,
  output logic               out_valid,
  output logic [3:0]         out_event_kind,
  output logic [6:0]         out_channel,
  output logic [13:0]        out_value,
  output logic [7:0]         out_sysex_command,
  output logic               out_last,
  output logic               out_overflow
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD_A = 4'b0010,
    S_RD_B = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  op_code_t         code_r, code_nxt;
  logic [3:0]       kind_r, kind_nxt;
  val_form_t        vform_r, vform_nxt;
  logic             chb_r, chb_nxt;
  logic [3:0]       ch_r, ch_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    end_r, end_nxt;
  logic [7:0]       a_r, a_nxt;

  logic [7:0]       frame_mem_r [FRAME_BYTES];
  logic [FRAME_BYTES-1:0] valid_r;
  logic [7:0]       rd_data_r;
  logic             rd_val_r;

  logic             out_valid_r;
  logic [3:0]       out_kind_r;
  logic [6:0]       out_chan_r;
  logic [13:0]      out_value_r;
  logic [7:0]       out_cmd_r;
  logic             out_last_r;
  logic             out_ovf_r;

  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic             clr;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [CW-1:0]    idx_plus1;
  logic [CW:0]      idx_plus3;
  logic [7:0]       rd_eff;
  logic [7:0]       a8;
  logic [7:0]       b8;
  logic [14:0]      wide_v;
  logic [7:0]       char_v;
  logic [13:0]      ev_value;
  logic [6:0]       ev_chan;
  logic             ev_last;
  logic             out_free;
  logic             out_load;

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign mem_we    = q_pop && (q_op.code == OP_WRITE || q_op.code == OP_FINISH);
  assign mem_wa    = q_arg[AW-1:0];
  assign clr       = q_pop && (q_op.code == OP_CLEAR);
  assign rd_en     = (state_r == S_RD_A) || (state_r == S_RD_B);
  assign idx_plus1 = idx_r + CW'(1);
  assign idx_plus3 = {1'b0, idx_r} + (CW + 1)'(3);
  assign rd_addr   = (state_r == S_RD_B) ? idx_plus1[AW-1:0] : idx_r[AW-1:0];
  assign rd_eff    = rd_val_r ? rd_data_r : 8'h00;
  assign out_free  = !out_valid_r || !out_stall;

  assign a8     = (code_r == OP_SYSEX) ? rd_eff : a_r;
  assign b8     = rd_eff;
  assign wide_v = {a8, 7'b0000000} + {7'b0000000, b8};
  assign char_v = a8 + {b8[0], 7'b0000000};

  always_comb begin
    case (vform_r)
      VF_WIDE: ev_value = wide_v[13:0];
      VF_BYTE: ev_value = {6'b000000, a8};
      VF_CHAR: ev_value = {6'b000000, char_v};
      default: ev_value = 14'd0;
    endcase
    ev_chan = chb_r ? b8[6:0] : {3'b000, ch_r};
    case (code_r)
      OP_SYSEX:  ev_last = (idx_plus1 == end_r);
      OP_STRING: ev_last = !(idx_plus3 < {1'b0, end_r});
      default:   ev_last = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    kind_nxt  = kind_r;
    vform_nxt = vform_r;
    chb_nxt   = chb_r;
    ch_nxt    = ch_r;
    cmd_nxt   = cmd_r;
    ovf_nxt   = ovf_r;
    idx_nxt   = idx_r;
    end_nxt   = end_r;
    a_nxt     = a_r;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          code_nxt  = q_op.code;
          kind_nxt  = q_op.kind;
          vform_nxt = q_op.vform;
          chb_nxt   = q_op.ch_from_b;
          ch_nxt    = q_op.ch;
          cmd_nxt   = q_op.cmd;
          ovf_nxt   = q_op.ovf;
          end_nxt   = q_arg;
          case (q_op.code)
            OP_CLEAR: begin
              if (q_op.emit) begin
                state_nxt = S_EMIT;
              end
            end
            OP_FIXED: begin
              state_nxt = S_EMIT;
            end
            OP_FINISH: begin
              idx_nxt   = '0;
              state_nxt = S_RD_A;
            end
            OP_SYSEX, OP_STRING: begin
              idx_nxt   = CW'(1);
              state_nxt = S_RD_A;
            end
            default: begin
            end
          endcase
        end
      end
      S_RD_A: begin
        state_nxt = (code_r == OP_SYSEX) ? S_EMIT : S_RD_B;
      end
      S_RD_B: begin
        a_nxt     = rd_eff;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (code_r == OP_SYSEX && !ev_last) begin
            idx_nxt   = idx_plus1;
            state_nxt = S_RD_A;
          end else if (code_r == OP_STRING && !ev_last) begin
            idx_nxt   = idx_r + CW'(2);
            state_nxt = S_RD_A;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr) begin
        valid_r <= '0;
      end else if (mem_we) begin
        valid_r[mem_wa] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    code_r  <= code_nxt;
    kind_r  <= kind_nxt;
    vform_r <= vform_nxt;
    chb_r   <= chb_nxt;
    ch_r    <= ch_nxt;
    cmd_r   <= cmd_nxt;
    ovf_r   <= ovf_nxt;
    idx_r   <= idx_nxt;
    end_r   <= end_nxt;
    a_r     <= a_nxt;
    if (out_load) begin
      out_kind_r  <= kind_r;
      out_chan_r  <= ev_chan;
      out_value_r <= ev_value;
      out_cmd_r   <= cmd_r;
      out_last_r  <= ev_last;
      out_ovf_r   <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem_r[mem_wa] <= q_op.data;
    end
    if (rd_en) begin
      rd_data_r <= frame_mem_r[rd_addr];
      rd_val_r  <= valid_r[rd_addr];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_kind    = out_kind_r;
  assign out_channel       = out_chan_r;
  assign out_value         = out_value_r;
  assign out_sysex_command = out_cmd_r;
  assign out_last          = out_last_r;
  assign out_overflow      = out_ovf_r;

`ifndef NO_ASSERTIONS
  a_walk_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && code_r == OP_SYSEX) |-> (idx_r < end_r))
    else $error("Sysex walk index ran past the frame length.");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !ev_last) |=> (state_r == S_RD_A))
    else $error("Result without last flag not followed by further reads.");
`endif

endmodule

`default_nettype wire

>>> design/firmata_message_parser_unit.sv
// Firmata message parser top level: joins the byte front end, the operation queue
// and the frame-store back end. Depends on fmp_pkg, fmp_front, fmp_fifo, fmp_back.
//
// The input channel takes one link byte per transaction (in_valid, in_stall). The
// result channel delivers one event per transaction (out_valid, out_stall) from an
// output register, so new bytes keep being accepted while a result waits.
// cfg_wr_en with cfg_wr_data writes the event enable mask.
// A byte is classified in the cycle it is accepted and queued as at most one operation.
// A request event goes from the queue straight to S_EMIT; a channel command first
// reads its two bytes from the single-port frame store in S_RD_A and S_RD_B.
// A sysex end walks the frame store: a data byte passes S_RD_A and S_EMIT, a string
// character S_RD_A, S_RD_B and S_EMIT. Other bytes cost at most one queue slot.
// in_stall rises only when the queue is full, which happens while the back end is busy
// reading the store, walking a frame or held by out_stall; a stalled result holds its value.
// Synchronous reset clears the parser, the queue, the store valid bits and sets
// the enable mask to all ones; no clearing pass is needed.
`default_nettype none

module firmata_message_parser_unit import fmp_pkg::*; #(
  parameter int FRAME_BYTES = FMP_FRAME_BYTES,
  parameter int QUEUE_DEPTH = FMP_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_event_kind,
  output logic [6:0]       out_channel,
  output logic [13:0]      out_value,
  output logic [7:0]       out_sysex_command,
  output logic             out_last,
  output logic             out_overflow
);

  localparam int CW = $clog2(FRAME_BYTES + 1);
  localparam int QW = $bits(fmp_op_t) + CW;

  logic          q_full;
  logic          q_empty;
  logic          push;
  logic          pop;
  fmp_op_t       push_op;
  logic [CW-1:0] push_arg;
  logic [QW-1:0] pop_data;
  fmp_op_t       pop_op;
  logic [CW-1:0] pop_arg;

  assign in_stall = q_full;
  assign pop_op   = fmp_op_t'(pop_data[QW-1:CW]);
  assign pop_arg  = pop_data[CW-1:0];

  fmp_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_byte     (in_byte),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .push        (push),
    .op          (push_op),
    .arg         (push_arg)
  );

  fmp_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_op, push_arg}),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  fmp_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_op              (pop_op),
    .q_arg             (pop_arg),
    .q_pop             (pop),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_event_kind    (out_event_kind),
    .out_channel       (out_channel),
    .out_value         (out_value),
    .out_sysex_command (out_sysex_command),
    .out_last          (out_last),
    .out_overflow      (out_overflow)
  );

endmodule

`default_nettype wire

>>> verif/firmata_message_parser_unit_tb.sv
// Self-checking testbench for firmata_message_parser_unit: random and directed link bytes
// are checked against a built-in parser model. Depends on fmp_pkg and the parser RTL.
`timescale 1ns / 100ps

module firmata_message_parser_unit_tb;
  import fmp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_LIMIT = 50000;
  localparam int SETTLE_CYCLES = 120;

  typedef struct packed {
    logic [3:0]  kind;
    logic [6:0]  channel;
    logic [13:0] value;
    logic [7:0]  command;
    logic        last;
    logic        ovf;
  } parser_event_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_event_kind;
  logic [6:0]  out_channel;
  logic [13:0] out_value;
  logic [7:0]  out_sysex_command;
  logic        out_last;
  logic        out_overflow;

  logic [7:0]    tx_bytes[$];
  parser_event_t pending_events[$];
  int            queued_total = 0;
  int            bytes_accepted = 0;
  int            error_count = 0;
  int            cycle_count = 0;
  logic          long_hold_req = 1'b0;

  // Parser model state.
  logic [7:0] enable_mask;
  logic       sx_active;
  logic [1:0] data_left;
  logic [7:0] open_cmd;
  logic [3:0] chan;
  logic [7:0] frame_buf[FMP_FRAME_BYTES];
  int         frame_len;
  logic       frame_ovf;

  firmata_message_parser_unit u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_event_kind(out_event_kind),
    .out_channel(out_channel),
    .out_value(out_value),
    .out_sysex_command(out_sysex_command),
    .out_last(out_last),
    .out_overflow(out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    error_count++;
    if (error_count <= 50) begin
      $display("ERROR (cycle %0d): %s", cycle_count, msg);
    end
  endtask

  function automatic void push_event(input logic [3:0] kind, input logic [6:0] ch,
                                     input logic [13:0] val, input logic [7:0] cmd,
                                     input logic last, input logic ovf);
    pending_events.push_back('{kind, ch, val, cmd, last, ovf});
  endfunction

  function automatic void clear_parser();
    sx_active = 1'b0;
    data_left = 2'd0;
    open_cmd = 8'h00;
    chan = 4'h0;
    foreach (frame_buf[i]) frame_buf[i] = 8'h00;
    frame_len = 0;
    frame_ovf = 1'b0;
  endfunction

  function automatic void close_frame();
    logic [7:0] cmd;
    logic [7:0] ch;
    int n;
    if (frame_len == 0) return;
    cmd = frame_buf[0];
    if (cmd == SX_FIRMWARE) begin
      push_event(EV_FIRMWARE, 7'd0, 14'd0, cmd, 1'b1, frame_ovf);
      return;
    end
    if (cmd == SX_STRING) begin
      if (!enable_mask[EN_STRING]) return;
      n = (frame_len - 1) / 2;
      if (n == 0) push_event(EV_STRING, 7'd0, 14'd0, cmd, 1'b1, frame_ovf);
      for (int i = 0; i < n; i++) begin
        ch = frame_buf[1 + 2 * i] + {frame_buf[2 + 2 * i][0], 7'b0};
        push_event(EV_STRING, 7'd0, {6'b0, ch}, cmd, i == n - 1, frame_ovf);
      end
      return;
    end
    if (!enable_mask[EN_SYSEX]) return;
    if (frame_len == 1) push_event(EV_SYSEX, 7'd0, 14'd0, cmd, 1'b1, frame_ovf);
    for (int i = 1; i < frame_len; i++) begin
      push_event(EV_SYSEX, 7'd0, {6'b0, frame_buf[i]}, cmd, i == frame_len - 1, frame_ovf);
    end
  endfunction

  function automatic void complete_command();
    logic [7:0]  first_slot;
    logic [7:0]  second_slot;
    logic [7:0]  cmd;
    logic [13:0] wide;
    first_slot = frame_buf[0];
    second_slot = frame_buf[1];
    cmd = open_cmd;
    open_cmd = 8'h00;
    wide = {first_slot[6:0], 7'b0} + {6'b0, second_slot};
    case (cmd)
      CMD_ANALOG: begin
        if (enable_mask[EN_ANALOG]) push_event(EV_ANALOG, {3'b0, chan}, wide, 8'h00, 1'b1, 1'b0);
      end
      CMD_DIGITAL: begin
        if (enable_mask[EN_DIGITAL]) push_event(EV_DIGITAL, {3'b0, chan}, wide, 8'h00, 1'b1, 1'b0);
      end
      CMD_PIN_MODE: begin
        if (enable_mask[EN_PIN_MODE]) begin
          push_event(EV_PIN_MODE, second_slot[6:0], {6'b0, first_slot}, 8'h00, 1'b1, 1'b0);
        end
      end
      CMD_REP_ANALOG: begin
        if (enable_mask[EN_REP_ANALOG]) begin
          push_event(EV_REP_ANALOG, {3'b0, chan}, {6'b0, first_slot}, 8'h00, 1'b1, 1'b0);
        end
      end
      CMD_REP_DIGITAL: begin
        if (enable_mask[EN_REP_DIGITAL]) begin
          push_event(EV_REP_DIGITAL, {3'b0, chan}, {6'b0, first_slot}, 8'h00, 1'b1, 1'b0);
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void parse_link_byte(input logic [7:0] b);
    logic [7:0] cmd;
    if (sx_active) begin
      if (b == CMD_SYSEX_END) begin
        sx_active = 1'b0;
        close_frame();
      end else if (frame_len < FMP_FRAME_BYTES) begin
        frame_buf[frame_len] = b;
        frame_len++;
      end else begin
        frame_ovf = 1'b1;
      end
      return;
    end
    if (data_left != 2'd0 && !b[7]) begin
      data_left = data_left - 2'd1;
      frame_buf[data_left[0]] = b;
      if (data_left == 2'd0 && open_cmd != 8'h00) complete_command();
      return;
    end
    if (b < CMD_SYSEX_START) begin
      cmd = b & STATUS_MASK;
      chan = b[3:0];
    end else begin
      cmd = b;
    end
    case (cmd)
      CMD_ANALOG, CMD_DIGITAL, CMD_PIN_MODE: begin
        data_left = 2'd2;
        open_cmd = cmd;
      end
      CMD_REP_ANALOG, CMD_REP_DIGITAL: begin
        data_left = 2'd1;
        open_cmd = cmd;
      end
      CMD_SYSEX_START: begin
        sx_active = 1'b1;
        frame_len = 0;
        frame_ovf = 1'b0;
      end
      CMD_RESET: begin
        clear_parser();
        if (enable_mask[EN_RESET]) push_event(EV_RESET, 7'd0, 14'd0, 8'h00, 1'b1, 1'b0);
      end
      CMD_VERSION: begin
        push_event(EV_VERSION, 7'd0, 14'd0, 8'h00, 1'b1, 1'b0);
      end
      default: begin
      end
    endcase
  endfunction

  // Driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin : driver
    int burst_left;
    int gap_left;
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (tx_bytes.size() != 0) begin
        in_valid <= 1'b1;
        in_byte <= tx_bytes.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall density changes over time, plus one long hold-off on request.
  always @(posedge clk) begin : receiver
    int  hold_left;
    int  mode_left;
    int  stall_pct;
    logic hold_taken;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
      mode_left = 0;
      stall_pct = 0;
      hold_taken = 1'b0;
    end else begin
      if (long_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(20, 200);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        mode_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Monitor: predicts on each accepted byte, checks each accepted event.
  always @(posedge clk) begin : monitor
    parser_event_t seen;
    parser_event_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        parse_link_byte(in_byte);
        bytes_accepted++;
      end
      if (out_valid && !out_stall) begin
        seen = {out_event_kind, out_channel, out_value, out_sysex_command, out_last,
                out_overflow};
        if (pending_events.size() == 0) begin
          flag_mismatch($sformatf("unexpected event kind %0d ch %0d value %0h cmd %0h",
                                  seen.kind, seen.channel, seen.value, seen.command));
        end else begin
          want = pending_events.pop_front();
          if (seen.kind !== want.kind || seen.channel !== want.channel ||
              seen.value !== want.value || seen.command !== want.command ||
              seen.last !== want.last || seen.ovf !== want.ovf) begin
            flag_mismatch($sformatf(
              "got kind %0d ch %0d val %0h cmd %0h last %0b ovf %0b, want %0d %0d %0h %0h %0b %0b",
              seen.kind, seen.channel, seen.value, seen.command, seen.last, seen.ovf,
              want.kind, want.channel, want.value, want.command, want.last, want.ovf));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout at cycle %0d", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic put_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
    queued_total++;
  endtask

  task automatic put_frame(input logic [7:0] cmd, input int len);
    logic [7:0] b;
    put_byte(CMD_SYSEX_START);
    for (int i = 0; i < len; i++) begin
      if (i == 0) begin
        b = cmd;
      end else if ($urandom_range(0, 6) == 0) begin
        b = 8'($urandom_range(0, 255));
        if (b == CMD_SYSEX_END) b = 8'h00;
      end else begin
        b = 8'($urandom_range(0, 127));
      end
      put_byte(b);
    end
    put_byte(CMD_SYSEX_END);
  endtask

  task automatic put_random_message();
    logic [7:0] status;
    logic [7:0] cmd;
    int sel;
    int len;
    sel = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: status = CMD_ANALOG;
      1: status = CMD_DIGITAL;
      2: status = CMD_REP_ANALOG;
      default: status = CMD_REP_DIGITAL;
    endcase
    status = status | 8'($urandom_range(0, 15));
    if (sel < 30) begin
      put_byte(status);
      put_byte(8'($urandom_range(0, 127)));
      if (status[7:4] == CMD_ANALOG[7:4] || status[7:4] == CMD_DIGITAL[7:4]) begin
        put_byte(8'($urandom_range(0, 127)));
      end
    end else if (sel < 40) begin
      put_byte(CMD_PIN_MODE);
      put_byte(8'($urandom_range(0, 127)));
      put_byte(8'($urandom_range(0, 127)));
    end else if (sel < 45) begin
      put_byte(CMD_VERSION);
    end else if (sel < 48) begin
      put_byte(CMD_RESET);
    end else if (sel < 80) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: cmd = SX_STRING;
        4: cmd = SX_FIRMWARE;
        default: begin
          cmd = 8'($urandom_range(0, 255));
          if (cmd == CMD_SYSEX_END) cmd = 8'h00;
        end
      endcase
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 12);
      put_frame(cmd, len);
    end else if (sel < 90) begin
      put_byte(status);
      put_byte(8'($urandom_range(128, 255)));
      put_byte(8'($urandom_range(0, 127)));
      if ($urandom_range(0, 1) == 1) put_byte(8'($urandom_range(0, 127)));
    end else begin
      len = $urandom_range(1, 3);
      repeat (len) put_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic put_random_stream(input int count);
    int target;
    target = queued_total + count;
    while (queued_total < target) put_random_message();
  endtask

  task automatic wait_idle();
    int waited;
    waited = 0;
    while ((bytes_accepted != queued_total || pending_events.size() != 0) &&
           waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(input logic [7:0] mask);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mask;
    enable_mask = mask;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic put_list(input logic [7:0] list[]);
    foreach (list[i]) put_byte(list[i]);
  endtask

  initial begin
    enable_mask = ENABLE_RESET;
    clear_parser();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    write_enable(ENABLE_RESET);
    put_list('{8'hE5, 8'h00, 8'h00, 8'hEF, 8'h7F, 8'h7F, 8'h90, 8'h01, 8'h7F});
    put_list('{8'hF4, 8'h0D, 8'h01, 8'hF4, 8'h7F, 8'h7F, 8'hC3, 8'h01, 8'hD2, 8'h00});
    put_list('{8'hF9, 8'hF0, 8'h71, 8'h41, 8'h00, 8'h7F, 8'h01, 8'h05, 8'hF7});
    put_list('{8'hF0, 8'h71, 8'h05, 8'hF7, 8'hF0, 8'hF7, 8'hF0, 8'h10, 8'hF7});
    put_list('{8'hF0, 8'h79, 8'hF7, 8'hF0, 8'h22, 8'h85, 8'hF0, 8'hFF, 8'h7F, 8'hF7});
    put_list('{8'hE2, 8'h10, 8'hA5, 8'h20, 8'hE0, 8'h11, 8'hF0, 8'h44, 8'h55, 8'hF7, 8'h22});
    put_list('{8'h33, 8'hF5, 8'hE0, 8'h11, 8'hFF, 8'h22});
    put_byte(CMD_SYSEX_START);
    put_byte(8'h33);
    for (int i = 0; i < 36; i++) put_byte(8'(i * 7));
    put_byte(CMD_SYSEX_END);
    wait_idle();

    // Every event disabled: state still advances, requests still come out.
    write_enable(8'h00);
    put_list('{8'hE0, 8'h01, 8'h02, 8'hF0, 8'h71, 8'h41, 8'h00, 8'hF7, 8'hF0, 8'h10});
    put_list('{8'h20, 8'hF7, 8'hFF, 8'hF9, 8'hF0, 8'h79, 8'hF7, 8'hC1, 8'h05});
    wait_idle();

    write_enable(8'h55);
    put_random_stream(80);
    wait_idle();

    write_enable(ENABLE_RESET);
    put_random_stream(200);
    long_hold_req = 1'b1;
    wait_idle();

    write_enable(8'($urandom_range(0, 255)));
    put_random_stream(100);
    wait_idle();

    if (pending_events.size() != 0) begin
      flag_mismatch($sformatf("%0d expected events never arrived", pending_events.size()));
    end
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> firmata_message_parser_unit.f
design/fmp_pkg.sv
design/fmp_front.sv
design/fmp_fifo.sv
design/fmp_back.sv
design/firmata_message_parser_unit.sv
verif/firmata_message_parser_unit_tb.sv
